// ===== rtl/pcmp_pkg.sv =====
// Shared types and constants for the PCM player with soft start and stop ramps.
// No dependencies; imported by every module of the block.
package pcmp_pkg;

    localparam int SampleW = 16;
    localparam int PhaseW  = 2;
    localparam int ShiftW  = 4;
    localparam int CfgIdxW = 2;

    // Sequencer phases
    localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
    localparam logic [PhaseW-1:0] PH_UP   = 2'd1;
    localparam logic [PhaseW-1:0] PH_PLAY = 2'd2;
    localparam logic [PhaseW-1:0] PH_DOWN = 2'd3;

    // Input opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_16BIT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_STEREO       = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_SHIFT = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_COUNT  = 2'd3;

    typedef struct packed {
        logic              sample_16bit;
        logic              stereo;
        logic [ShiftW-1:0] sample_shift;
        logic [SampleW-1:0] frame_count;
    } cfg_t;

    typedef struct packed {
        logic [SampleW-1:0] left_duty;
        logic [SampleW-1:0] right_duty;
        logic [PhaseW-1:0]  phase;
        logic               frame_taken;
        logic               start_accepted;
    } res_t;

endpackage

// ===== rtl/pcmp_frame_dec.sv =====
// Frame decoder: turns the offered raw samples into 16-bit levels.
// Depends on pcmp_pkg (cfg_t, widths).
module pcmp_frame_dec
    import pcmp_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [SampleW-1:0] left_sample,
    input  logic [SampleW-1:0] right_sample,
    output logic [SampleW-1:0] left_level,
    output logic [SampleW-1:0] right_level
);

    logic [SampleW-1:0] left_conv;
    logic [SampleW-1:0] right_conv;

    // Use the raw word in 16-bit mode, else shift the low byte, keeping 16 bits
    always_comb
    begin
        if (cfg.sample_16bit)
        begin
            left_conv  = left_sample;
            right_conv = right_sample;
        end
        else
        begin
            left_conv  = {8'd0, left_sample[7:0]} << cfg.sample_shift;
            right_conv = {8'd0, right_sample[7:0]} << cfg.sample_shift;
        end
    end

    // Copy left to right in mono
    assign left_level  = left_conv;
    assign right_level = cfg.stereo ? right_conv : left_conv;

endmodule

// ===== rtl/pcmp_seq.sv =====
// Playback sequencer: phase, ramp levels, targets and frame index, one step per item.
// Depends on pcmp_pkg and pcmp_frame_dec.
module pcmp_seq
    import pcmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               advance,
    input  logic               op,
    input  logic [SampleW-1:0] left_sample,
    input  logic [SampleW-1:0] right_sample,
    output res_t               res
);

    logic [PhaseW-1:0]  phase_reg,    phase_next;
    logic [SampleW-1:0] left_lvl_reg, left_lvl_next;
    logic [SampleW-1:0] right_lvl_reg, right_lvl_next;
    logic [SampleW-1:0] left_tgt_reg, left_tgt_next;
    logic [SampleW-1:0] right_tgt_reg, right_tgt_next;
    logic [SampleW-1:0] frame_idx_reg, frame_idx_next;
    logic [SampleW-1:0] left_frame;
    logic [SampleW-1:0] right_frame;
    logic               taken;
    logic               accepted;

    pcmp_frame_dec u_dec (
        .cfg          (cfg),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .left_level   (left_frame),
        .right_level  (right_frame)
    );

    // Compute the state after this item
    always_comb
    begin
        phase_next     = phase_reg;
        left_lvl_next  = left_lvl_reg;
        right_lvl_next = right_lvl_reg;
        left_tgt_next  = left_tgt_reg;
        right_tgt_next = right_tgt_reg;
        frame_idx_next = frame_idx_reg;
        taken          = 1'b0;
        accepted       = 1'b0;
        if (op == OP_START)
        begin
            // Start only from idle; capture the frame as targets
            if (phase_reg == PH_IDLE)
            begin
                accepted       = 1'b1;
                phase_next     = PH_UP;
                frame_idx_next = '0;
                left_lvl_next  = '0;
                right_lvl_next = '0;
                left_tgt_next  = left_frame;
                right_tgt_next = right_frame;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_UP:
                begin
                    if (left_lvl_reg < left_tgt_reg)
                        left_lvl_next = left_lvl_reg + 16'd1;
                    if (right_lvl_reg < right_tgt_reg)
                        right_lvl_next = right_lvl_reg + 16'd1;
                    if (left_lvl_next == left_tgt_reg && right_lvl_next == right_tgt_reg)
                        phase_next = PH_PLAY;
                end
                PH_PLAY:
                begin
                    if (frame_idx_reg >= cfg.frame_count)
                        phase_next = PH_DOWN;
                    else
                    begin
                        left_lvl_next  = left_frame;
                        right_lvl_next = right_frame;
                        taken          = 1'b1;
                    end
                    frame_idx_next = frame_idx_reg + 16'd1;
                end
                PH_DOWN:
                begin
                    if (left_lvl_reg != '0)
                        left_lvl_next = left_lvl_reg - 16'd1;
                    if (right_lvl_reg != '0)
                        right_lvl_next = right_lvl_reg - 16'd1;
                    if (left_lvl_next == '0 && right_lvl_next == '0)
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    // Idle tick: hold everything
                end
            endcase
        end
    end

    // Advance state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            left_lvl_reg  <= '0;
            right_lvl_reg <= '0;
            left_tgt_reg  <= '0;
            right_tgt_reg <= '0;
            frame_idx_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            left_lvl_reg  <= left_lvl_next;
            right_lvl_reg <= right_lvl_next;
            left_tgt_reg  <= left_tgt_next;
            right_tgt_reg <= right_tgt_next;
            frame_idx_reg <= frame_idx_next;
        end
    end

    assign res.left_duty      = left_lvl_next;
    assign res.right_duty     = right_lvl_next;
    assign res.phase          = phase_next;
    assign res.frame_taken    = taken;
    assign res.start_accepted = accepted;

endmodule

// ===== rtl/pcm_player_with_pop_free_ramps_top.sv =====
// The result is registered: it appears on the output register in the cycle after the input transfer.
// Throughput: one item per cycle while the input is not stalled; the sequencer state updates in the cycle an
// item is taken, so each item sees the state its predecessor left.
// Input stalls only while the output register holds a result that is stalled.
// Reset (rst_n low, asynchronous): idle phase, levels, targets, frame index and
// configuration registers cleared, output register empty.
module pcm_player_with_pop_free_ramps_top
    import pcmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [SampleW-1:0] left_sample,
    input  logic [SampleW-1:0] right_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SampleW-1:0] left_duty,
    output logic [SampleW-1:0] right_duty,
    output logic [PhaseW-1:0]  phase,
    output logic               frame_taken,
    output logic               start_accepted,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [SampleW-1:0] cfg_data
);

    cfg_t cfg_reg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic in_xfer;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_16BIT: cfg_reg.sample_16bit <= cfg_data[0];
                CFG_STEREO:       cfg_reg.stereo       <= cfg_data[0];
                CFG_SAMPLE_SHIFT: cfg_reg.sample_shift <= cfg_data[ShiftW-1:0];
                CFG_FRAME_COUNT:  cfg_reg.frame_count  <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    pcmp_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .advance      (in_xfer),
        .op           (op),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .res          (res)
    );

    // Hold the output valid until the result transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Load the result register on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign left_duty      = res_reg.left_duty;
    assign right_duty     = res_reg.right_duty;
    assign phase          = res_reg.phase;
    assign frame_taken    = res_reg.frame_taken;
    assign start_accepted = res_reg.start_accepted;

    // An accepted start always opens a ramp from zero
    a_start_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_accepted |-> phase == PH_UP && left_duty == '0 && right_duty == '0)
        else $error("start accepted without a zero ramp-up");

    // Frames are consumed only while playing
    a_taken_play: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_taken |-> phase == PH_PLAY && !start_accepted)
        else $error("frame taken outside playback");

    // A held result is not overwritten while stalled
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_reg))
        else $error("stalled result changed");

endmodule
